// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/dtgr_pkg.sv -----
// ----------------------------------------------------------------------------
// dtgr_pkg
// Types, constants and the 5x7 column font shared by the glyph renderer.
// ----------------------------------------------------------------------------
package dtgr_pkg;

    localparam int GLYPH_WIDTH = 5;
    localparam int COL_W       = 3;
    localparam int BLANK_W     = 2;
    localparam int BCD_DIGITS  = 5;
    localparam int BIN_W       = 16;
    localparam int FONT_ENTRIES = 95 * GLYPH_WIDTH;
    localparam int FONT_IDX_W  = $clog2(FONT_ENTRIES);

    localparam logic [6:0] FIRST_CODE = 7'd32;
    localparam logic [6:0] LAST_CODE  = 7'd126;
    localparam logic [6:0] CODE_SPACE = 7'd32;
    localparam logic [6:0] CODE_ZERO  = 7'd48;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);

    // one glyph waiting to be drawn
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } glyph_cmd_t;

    localparam logic [6:0] FONT_COLS [0:FONT_ENTRIES-1] = '{
        7'h00,7'h00,7'h00,7'h00,7'h00, 7'h00,7'h00,7'h5F,7'h00,7'h00,
        7'h00,7'h07,7'h00,7'h07,7'h00, 7'h14,7'h7F,7'h14,7'h7F,7'h14,
        7'h24,7'h2A,7'h7F,7'h2A,7'h12, 7'h23,7'h13,7'h08,7'h64,7'h62,
        7'h36,7'h49,7'h55,7'h22,7'h50, 7'h00,7'h00,7'h03,7'h00,7'h00,
        7'h00,7'h1C,7'h22,7'h41,7'h00, 7'h00,7'h41,7'h22,7'h1C,7'h00,
        7'h14,7'h08,7'h3E,7'h08,7'h14, 7'h08,7'h08,7'h3E,7'h08,7'h08,
        7'h00,7'h50,7'h30,7'h00,7'h00, 7'h08,7'h08,7'h08,7'h08,7'h08,
        7'h00,7'h60,7'h60,7'h00,7'h00, 7'h20,7'h10,7'h08,7'h04,7'h02,
        7'h3E,7'h51,7'h49,7'h45,7'h3E, 7'h00,7'h42,7'h7F,7'h40,7'h00,
        7'h62,7'h51,7'h49,7'h49,7'h46, 7'h22,7'h41,7'h49,7'h49,7'h36,
        7'h18,7'h14,7'h12,7'h7F,7'h10, 7'h27,7'h45,7'h45,7'h45,7'h39,
        7'h3C,7'h4A,7'h49,7'h49,7'h30, 7'h01,7'h71,7'h09,7'h05,7'h03,
        7'h36,7'h49,7'h49,7'h49,7'h36, 7'h06,7'h49,7'h49,7'h29,7'h1E,
        7'h00,7'h36,7'h36,7'h00,7'h00, 7'h00,7'h56,7'h36,7'h00,7'h00,
        7'h08,7'h14,7'h22,7'h41,7'h00, 7'h14,7'h14,7'h14,7'h14,7'h14,
        7'h00,7'h41,7'h22,7'h14,7'h08, 7'h02,7'h01,7'h51,7'h09,7'h06,
        7'h32,7'h49,7'h79,7'h41,7'h3E, 7'h7C,7'h12,7'h11,7'h12,7'h7C,
        7'h41,7'h7F,7'h49,7'h49,7'h36, 7'h3E,7'h41,7'h41,7'h41,7'h22,
        7'h41,7'h7F,7'h41,7'h41,7'h3E, 7'h7F,7'h49,7'h49,7'h49,7'h41,
        7'h7F,7'h09,7'h09,7'h09,7'h01, 7'h3E,7'h41,7'h41,7'h49,7'h7A,
        7'h7F,7'h08,7'h08,7'h08,7'h7F, 7'h00,7'h41,7'h7F,7'h41,7'h00,
        7'h20,7'h40,7'h41,7'h3F,7'h01, 7'h7F,7'h08,7'h14,7'h22,7'h41,
        7'h7F,7'h40,7'h40,7'h40,7'h40, 7'h7F,7'h02,7'h0C,7'h02,7'h7F,
        7'h7F,7'h04,7'h08,7'h10,7'h7F, 7'h3E,7'h41,7'h41,7'h41,7'h3E,
        7'h7F,7'h09,7'h09,7'h09,7'h06, 7'h3E,7'h41,7'h51,7'h21,7'h5E,
        7'h7F,7'h09,7'h19,7'h29,7'h46, 7'h26,7'h49,7'h49,7'h49,7'h32,
        7'h01,7'h01,7'h7F,7'h01,7'h01, 7'h3F,7'h40,7'h40,7'h40,7'h3F,
        7'h1F,7'h20,7'h40,7'h20,7'h1F, 7'h3F,7'h40,7'h38,7'h40,7'h3F,
        7'h63,7'h14,7'h08,7'h14,7'h63, 7'h07,7'h08,7'h70,7'h08,7'h07,
        7'h61,7'h51,7'h49,7'h45,7'h43, 7'h00,7'h7F,7'h41,7'h41,7'h00,
        7'h02,7'h04,7'h08,7'h10,7'h20, 7'h00,7'h41,7'h41,7'h7F,7'h00,
        7'h04,7'h02,7'h01,7'h02,7'h04, 7'h40,7'h40,7'h40,7'h40,7'h40,
        7'h00,7'h01,7'h02,7'h04,7'h00, 7'h20,7'h54,7'h54,7'h54,7'h78,
        7'h7F,7'h48,7'h44,7'h44,7'h38, 7'h38,7'h44,7'h44,7'h44,7'h20,
        7'h38,7'h44,7'h44,7'h48,7'h7F, 7'h38,7'h54,7'h54,7'h54,7'h18,
        7'h08,7'h7E,7'h09,7'h01,7'h02, 7'h08,7'h54,7'h54,7'h54,7'h3C,
        7'h7F,7'h08,7'h04,7'h04,7'h78, 7'h00,7'h48,7'h7D,7'h40,7'h00,
        7'h20,7'h40,7'h44,7'h3D,7'h00, 7'h7F,7'h10,7'h28,7'h44,7'h00,
        7'h00,7'h41,7'h7F,7'h40,7'h00, 7'h7C,7'h04,7'h78,7'h04,7'h78,
        7'h7C,7'h08,7'h04,7'h04,7'h78, 7'h38,7'h44,7'h44,7'h44,7'h38,
        7'h7C,7'h14,7'h14,7'h14,7'h08, 7'h08,7'h14,7'h14,7'h18,7'h7C,
        7'h7C,7'h08,7'h04,7'h04,7'h08, 7'h48,7'h54,7'h54,7'h54,7'h20,
        7'h04,7'h3F,7'h44,7'h40,7'h20, 7'h3C,7'h40,7'h40,7'h20,7'h7C,
        7'h1C,7'h20,7'h40,7'h20,7'h1C, 7'h3C,7'h40,7'h30,7'h40,7'h3C,
        7'h44,7'h28,7'h10,7'h28,7'h44, 7'h0C,7'h50,7'h50,7'h50,7'h3C,
        7'h44,7'h64,7'h54,7'h4C,7'h44, 7'h00,7'h08,7'h36,7'h41,7'h00,
        7'h00,7'h00,7'h7F,7'h00,7'h00, 7'h00,7'h41,7'h36,7'h08,7'h00,
        7'h10,7'h08,7'h08,7'h10,7'h08
    };

    // column of a glyph; codes outside the printable range draw as space
    function automatic logic [6:0] font_column(input logic [6:0] code,
                                               input logic [COL_W-1:0] col);
        logic [6:0]            c;
        logic [FONT_IDX_W-1:0] idx;
        c   = (code < FIRST_CODE || code > LAST_CODE) ? CODE_SPACE : code;
        idx = FONT_IDX_W'(c - FIRST_CODE) * FONT_IDX_W'(GLYPH_WIDTH) + FONT_IDX_W'(col);
        return FONT_COLS[idx];
    endfunction

endpackage

// ----- rtl/decimal_text_glyph_renderer_core.sv -----
// ----------------------------------------------------------------------------
// decimal_text_glyph_renderer_core
// Renders a printable character or a decimal number as 5x7 font columns.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// input     in         push / full        kind, character, number
// result    out        empty / pop        column_bits, glyph_end, last
//
// a character item gives 5 columns; a nonzero number gives 5 per digit plus 5
// per trailing blank, at most 40 columns; zero gives a single glyph
// a character is queued from S_CHAR once the queue has room; a number runs
// through the shift-add-3 converter, then S_SCAN queues its digits and S_BLANK
// its trailing blanks, both waiting while the queue is full; a new item is taken once all glyphs are queued
// the column sequencer sends one column per cycle while the queue holds a glyph,
// so output runs at one result per cycle while pop stays high
// reset clears the queue, the front state and the output valid register
// ----------------------------------------------------------------------------
module decimal_text_glyph_renderer_core
    import dtgr_pkg::*;
#(
    parameter int TRAIL_BLANKS = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             kind,
    input  logic [6:0]       character,
    input  logic [BIN_W-1:0] number,
    output logic             empty,
    input  logic             pop,
    output logic [6:0]       column_bits,
    output logic             glyph_end,
    output logic             last
);

    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    glyph_cmd_t q_wdata;
    glyph_cmd_t q_rdata;

    dtgr_front #(
        .TRAIL_BLANKS (TRAIL_BLANKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .character (character),
        .number    (number),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    dtgr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wdata),
        .wr_full  (q_full),
        .rd_en    (q_pop),
        .rd_data  (q_rdata),
        .rd_empty (q_empty)
    );

    dtgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .column_bits (column_bits),
        .glyph_end   (glyph_end),
        .last        (last)
    );

endmodule

// ----- rtl/dtgr_front.sv -----
// ----------------------------------------------------------------------------
// dtgr_front
// Accepts items, converts numbers to decimal by shift-add-3 and queues the
// glyph codes to draw, skipping leading zeros and adding trailing blanks.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtgr_front
    import dtgr_pkg::*;
#(
    parameter int TRAIL_BLANKS = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic             kind,
    input  logic [6:0]       character,
    input  logic [BIN_W-1:0] number,
    output logic             q_push,
    output glyph_cmd_t       q_data,
    input  logic             q_full
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHAR  = 3'd1;
    localparam logic [2:0] S_CONV  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_BLANK = 3'd4;

    localparam int BCD_W = 4 * BCD_DIGITS;
    localparam logic [3:0] CONV_LAST = 4'(BIN_W - 1);
    localparam logic [2:0] TOP_DIGIT = 3'(BCD_DIGITS - 1);
    localparam logic       NO_BLANKS = (TRAIL_BLANKS == 0);

    logic [2:0]         state_reg, state_next;
    logic [6:0]         code_reg, code_next;
    logic [BIN_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [2:0]         idx_reg, idx_next;
    logic               started_reg, started_next;
    logic               zero_reg, zero_next;
    logic [BLANK_W-1:0] blank_reg, blank_next;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit;
    logic               accept;
    logic               digit_last;

    assign full   = (state_reg != S_IDLE);
    assign accept = push && !full;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    assign digit      = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign digit_last = (idx_reg == 3'd0) && (zero_reg || NO_BLANKS);

    always_comb
    begin
        state_next   = state_reg;
        code_next    = code_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        started_next = started_reg;
        zero_next    = zero_reg;
        blank_next   = blank_reg;
        q_push       = 1'b0;
        q_data       = '{code: CODE_SPACE, last: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_next = character;
                    bin_next  = number;
                    bcd_next  = '0;
                    cnt_next  = '0;
                    zero_next = (number == '0);
                    state_next = kind ? S_CONV : S_CHAR;
                end
            end
            S_CHAR:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    q_data     = '{code: code_reg, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            S_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[BIN_W-1]};
                bin_next = {bin_reg[BIN_W-2:0], 1'b0};
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == CONV_LAST)
                begin
                    idx_next     = TOP_DIGIT;
                    started_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // leading zeros are dropped, the units digit always goes out
                if (!started_reg && digit == 4'd0 && idx_reg != 3'd0)
                begin
                    idx_next = idx_reg - 3'd1;
                end
                else if (!q_full)
                begin
                    q_push       = 1'b1;
                    q_data       = '{code: CODE_ZERO + {3'b000, digit}, last: digit_last};
                    started_next = 1'b1;
                    if (idx_reg == 3'd0)
                    begin
                        blank_next = BLANK_W'(TRAIL_BLANKS - 1);
                        state_next = digit_last ? S_IDLE : S_BLANK;
                    end
                    else
                    begin
                        idx_next = idx_reg - 3'd1;
                    end
                end
            end
            S_BLANK:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    q_data = '{code: CODE_SPACE, last: (blank_reg == '0)};
                    if (blank_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        blank_next = blank_reg - BLANK_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg    <= code_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        started_reg <= started_next;
        zero_reg    <= zero_next;
        blank_reg   <= blank_next;
    end

    `ASSERT_CLK(a_accept_busy, accept |=> (state_reg == S_CHAR || state_reg == S_CONV), "front not busy after accept")
    `ASSERT_NEVER(a_scan_idx, state_reg == S_SCAN && idx_reg > TOP_DIGIT, "digit index out of range")

endmodule

// ----- rtl/dtgr_fifo.sv -----
// ----------------------------------------------------------------------------
// dtgr_fifo
// Short glyph queue that decouples the front from the column sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtgr_fifo
    import dtgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  glyph_cmd_t wr_data,
    output logic       wr_full,
    input  logic       rd_en,
    output glyph_cmd_t rd_data,
    output logic       rd_empty
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    glyph_cmd_t         mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]     cnt_reg;

    assign wr_full  = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign rd_empty = (cnt_reg == '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
        end
    end

    `ASSERT_NEVER(a_no_overflow, wr_en && wr_full, "glyph queue written while full")
    `ASSERT_NEVER(a_no_underflow, rd_en && rd_empty, "glyph queue read while empty")

endmodule

// ----- rtl/dtgr_back.sv -----
// ----------------------------------------------------------------------------
// dtgr_back
// Walks each queued glyph through its five font columns into the output
// register, one column per cycle while the register is free or being taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtgr_back
    import dtgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  glyph_cmd_t q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] column_bits,
    output logic       glyph_end,
    output logic       last
);

    logic [COL_W-1:0] col_reg;
    logic             out_valid_reg;
    logic [6:0]       col_bits_reg;
    logic             gend_reg;
    logic             last_reg;
    logic             load;
    logic             end_col;

    assign end_col = (col_reg == LAST_COL);
    // output register refills whenever it is free or being taken and the queue holds a glyph
    assign load    = !q_empty && (!out_valid_reg || pop);
    assign q_pop   = load && end_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                col_reg <= end_col ? '0 : col_reg + COL_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            col_bits_reg <= font_column(q_data.code, col_reg);
            gend_reg     <= end_col;
            last_reg     <= end_col && q_data.last;
        end
    end

    assign empty       = !out_valid_reg;
    assign column_bits = col_bits_reg;
    assign glyph_end   = gend_reg;
    assign last        = last_reg;

    `ASSERT_NEVER(a_col_range, col_reg > LAST_COL, "column counter past glyph width")
    `ASSERT_CLK(a_last_on_end, (out_valid_reg && last_reg) |-> gend_reg, "last without glyph end")

endmodule

// ----- tb/glyph_column_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_column_monitor
// Watches both queue ports of the glyph renderer, works out the font columns
// each accepted item must produce and compares every popped column with them.
// ----------------------------------------------------------------------------
module glyph_column_monitor
    import dtgr_pkg::*;
#(
    parameter int TRAIL_BLANKS = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  logic             kind,
    input  logic [6:0]       character,
    input  logic [BIN_W-1:0] number,
    input  logic             empty,
    input  logic             pop,
    input  logic [6:0]       column_bits,
    input  logic             glyph_end,
    input  logic             last,
    output int               pending_results,
    output int               mismatch_count
);

    localparam logic [6:0] SPACE_CODE = 7'd32;
    localparam logic [6:0] DIGIT_ZERO = 7'd48;
    localparam logic [6:0] PRINT_LOW  = 7'd32;
    localparam logic [6:0] PRINT_HIGH = 7'd126;

    typedef struct packed {
        logic [6:0] bits;
        logic       glyph_end;
        logic       last;
    } glyph_column_t;

    // 5x7 font, five columns per code from space to tilde
    localparam logic [7:0] GLYPH_FONT [0:474] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,
        8'h00,8'h07,8'h00,8'h07,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,
        8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
        8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h00,8'h03,8'h00,8'h00,
        8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,
        8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
        8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,
        8'h00,8'h60,8'h60,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,
        8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
        8'h62,8'h51,8'h49,8'h49,8'h46, 8'h22,8'h41,8'h49,8'h49,8'h36,
        8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h27,8'h45,8'h45,8'h45,8'h39,
        8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
        8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E,
        8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,
        8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
        8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06,
        8'h32,8'h49,8'h79,8'h41,8'h3E, 8'h7C,8'h12,8'h11,8'h12,8'h7C,
        8'h41,8'h7F,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
        8'h41,8'h7F,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41,
        8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h3E,8'h41,8'h41,8'h49,8'h7A,
        8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
        8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41,
        8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h7F,8'h02,8'h0C,8'h02,8'h7F,
        8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
        8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E,
        8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h26,8'h49,8'h49,8'h49,8'h32,
        8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
        8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F,
        8'h63,8'h14,8'h08,8'h14,8'h63, 8'h07,8'h08,8'h70,8'h08,8'h07,
        8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h00,
        8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00,
        8'h04,8'h02,8'h01,8'h02,8'h04, 8'h40,8'h40,8'h40,8'h40,8'h40,
        8'h00,8'h01,8'h02,8'h04,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
        8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20,
        8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h38,8'h54,8'h54,8'h54,8'h18,
        8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h08,8'h54,8'h54,8'h54,8'h3C,
        8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h48,8'h7D,8'h40,8'h00,
        8'h20,8'h40,8'h44,8'h3D,8'h00, 8'h7F,8'h10,8'h28,8'h44,8'h00,
        8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h78,8'h04,8'h78,
        8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38,
        8'h7C,8'h14,8'h14,8'h14,8'h08, 8'h08,8'h14,8'h14,8'h18,8'h7C,
        8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
        8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C,
        8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h3C,8'h40,8'h30,8'h40,8'h3C,
        8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
        8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h00,
        8'h00,8'h00,8'h7F,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,
        8'h10,8'h08,8'h08,8'h10,8'h08
    };

    glyph_column_t expected_columns [$];
    int            fail_total = 0;

    // queue up the columns one item must produce
    task automatic render_item(input logic is_number, input logic [6:0] code_in,
                               input logic [BIN_W-1:0] value);
        logic [6:0]       glyph_codes [0:7];
        logic [3:0]       digits [0:4];
        logic [BIN_W-1:0] rest;
        logic [6:0]       code;
        int               n_glyphs;
        int               n_digits;
        int               idx;
        glyph_column_t    col;
        n_glyphs = 0;
        n_digits = 0;
        if (!is_number) begin
            glyph_codes[0] = code_in;
            n_glyphs = 1;
        end else if (value == '0) begin
            glyph_codes[0] = DIGIT_ZERO;
            n_glyphs = 1;
        end else begin
            rest = value;
            while (rest != '0) begin
                digits[n_digits] = 4'(rest % 10);
                rest = rest / 10;
                n_digits++;
            end
            for (int k = n_digits - 1; k >= 0; k--) begin
                glyph_codes[n_glyphs] = DIGIT_ZERO + 7'(digits[k]);
                n_glyphs++;
            end
            for (int k = 0; k < TRAIL_BLANKS; k++) begin
                glyph_codes[n_glyphs] = SPACE_CODE;
                n_glyphs++;
            end
        end
        for (int g = 0; g < n_glyphs; g++) begin
            code = glyph_codes[g];
            // anything outside the printable range draws as a space
            if (code < PRINT_LOW || code > PRINT_HIGH)
                code = SPACE_CODE;
            for (int c = 0; c < 5; c++) begin
                idx = (int'(code) - 32) * 5 + c;
                col.bits      = GLYPH_FONT[idx][6:0];
                col.glyph_end = (c == 4);
                col.last      = (g == n_glyphs - 1) && (c == 4);
                expected_columns.push_back(col);
            end
        end
    endtask

    always @(posedge clk) begin
        glyph_column_t want;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_columns.size() == 0) begin
                    $display("%0t: unexpected column, got bits %h end %b last %b",
                             $time, column_bits, glyph_end, last);
                    fail_total++;
                end else begin
                    want = expected_columns.pop_front();
                    if (column_bits !== want.bits || glyph_end !== want.glyph_end ||
                        last !== want.last) begin
                        $display("%0t: expected bits %h end %b last %b, got bits %h end %b last %b",
                                 $time, want.bits, want.glyph_end, want.last,
                                 column_bits, glyph_end, last);
                        fail_total++;
                    end
                end
            end
            if (push && !full)
                render_item(kind, character, number);
        end
        pending_results <= expected_columns.size();
        mismatch_count  <= fail_total;
    end

endmodule

// ----- tb/decimal_text_glyph_renderer_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_glyph_renderer_core_tb
// Feeds characters and decimal numbers into the glyph renderer with random
// gaps on both queue ports, one long output stall to fill the block, and
// leaves column checking to the monitor.
// ----------------------------------------------------------------------------
module decimal_text_glyph_renderer_core_tb
    import dtgr_pkg::*;
();

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 148;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 150;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    logic             kind;
    logic [6:0]       character;
    logic [BIN_W-1:0] number;
    logic             empty;
    logic             pop;
    logic [6:0]       column_bits;
    logic             glyph_end;
    logic             last;
    int               pending_results;
    int               mismatch_count;
    int               idle_cycles;

    decimal_text_glyph_renderer_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .character   (character),
        .number      (number),
        .empty       (empty),
        .pop         (pop),
        .column_bits (column_bits),
        .glyph_end   (glyph_end),
        .last        (last)
    );

    glyph_column_monitor monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .character       (character),
        .number          (number),
        .empty           (empty),
        .pop             (pop),
        .column_bits     (column_bits),
        .glyph_end       (glyph_end),
        .last            (last),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic k, input logic [6:0] ch, input logic [BIN_W-1:0] n);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        kind      <= k;
        character <= ch;
        number    <= n;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic send_char(input logic [6:0] ch);
        send_item(1'b0, ch, BIN_W'($urandom));
    endtask

    task automatic send_number(input logic [BIN_W-1:0] n);
        send_item(1'b1, 7'($urandom), n);
    endtask

    function automatic logic [BIN_W-1:0] pick_number();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return BIN_W'(65535 - $urandom_range(0, 9));
            2:       return BIN_W'($urandom_range(1, 9));
            3:       return BIN_W'($urandom_range(10, 99));
            4:       return BIN_W'($urandom_range(100, 999));
            5:       return BIN_W'($urandom_range(1000, 9999));
            6:       return BIN_W'($urandom_range(10000, 59999));
            7:       return BIN_W'($urandom_range(60000, 65535));
            default: return BIN_W'($urandom);
        endcase
    endfunction

    // stimulus and verdict
    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        kind      = 1'b0;
        character = '0;
        number    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: font ends, nonprintable codes, digit-count boundaries
        send_char(7'd32);
        send_char(7'd126);
        send_char(7'd65);
        send_char(7'd48);
        send_char(7'd0);
        send_char(7'd31);
        send_char(7'd127);
        send_char(7'd64);
        send_number(16'd0);
        send_item(1'b1, 7'h7F, 16'd0);
        send_number(16'd1);
        send_number(16'd9);
        send_number(16'd10);
        send_number(16'd99);
        send_number(16'd100);
        send_number(16'd1000);
        send_number(16'd10000);
        send_number(16'd59999);
        send_number(16'd65535);
        send_number(16'd12345);
        // 67890 wrapped to 16 bits
        send_number(16'd2354);
        send_item(1'b1, 7'h00, 16'hFFFF);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 99) < 85)
                    send_char(7'($urandom_range(32, 126)));
                else
                    send_char(7'($urandom_range(0, 127)));
            end else begin
                send_number(pick_number());
            end
        end
        push <= 1'b0;

        // let the monitor see the last item before waiting on it
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("decimal_text_glyph_renderer_core: match");
        else
            $display("decimal_text_glyph_renderer_core: mismatch");
        $finish;
    end

    // result side: bursts of pop with random gaps, one long hold-off
    initial
    begin
        int  burst;
        int  gap;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        pop   = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            burst = $urandom_range(1, 40);
            pop <= 1'b1;
            repeat (burst) begin
                @(posedge clk);
                if (!empty)
                    taken++;
            end
            if (!held && taken >= HOLD_AFTER) begin
                // sender keeps offering items so the block backs up
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("decimal_text_glyph_renderer_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
